>>> src/fltpm_pkg.sv
// ----------------------------------------------------------------------------
// fltpm_pkg
// Shared types, constants and helpers for the four-level page table mapper.
// ----------------------------------------------------------------------------
package fltpm_pkg;

    localparam int NUM_TABLES_DEF    = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int PAGE_SHIFT        = 12;
    localparam int PFN_W             = 40;   // bits 51:12 of a physical address
    localparam int ENTRY_W           = 64;

    localparam int VIRT_W            = 48;
    localparam int PHYS_W            = 52;
    localparam int BASE_W            = 52;

    localparam int S_TDATA_W         = 168;  // 164 bits of fields, padded to bytes
    localparam int M_TDATA_W         = 72;

    localparam int SHIFT_L4          = 39;
    localparam int SHIFT_L3          = 30;
    localparam int SHIFT_L2          = 21;
    localparam int SHIFT_L1          = 12;

    localparam logic [ENTRY_W-1:0] LINK_FLAGS = 64'h3;   // present | write
    localparam int                 BIT_PRESENT = 0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_SLOT = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } fltpm_alu_op_t;

    // Table index for a walk level; level 0 is the root.
    function automatic logic [IDX_W-1:0] page_index(input logic [VIRT_W-1:0] va,
                                                    input logic [1:0]        lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            2'd0:    idx = va[SHIFT_L4 +: IDX_W];
            2'd1:    idx = va[SHIFT_L3 +: IDX_W];
            2'd2:    idx = va[SHIFT_L2 +: IDX_W];
            default: idx = va[SHIFT_L1 +: IDX_W];
        endcase
        return idx;
    endfunction

    function automatic logic [ENTRY_W-1:0] pfn_to_addr(input logic [PFN_W-1:0] pfn);
        return {12'b0, pfn, 12'b0};
    endfunction

endpackage

>>> src/fltpm_ram.sv
// ----------------------------------------------------------------------------
// fltpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fltpm_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fltpm_alu.sv
// ----------------------------------------------------------------------------
// fltpm_alu
// Shared 64-bit add/subtract unit: link address build and link offset decode.
// ----------------------------------------------------------------------------
module fltpm_alu (
    input  fltpm_pkg::fltpm_alu_op_t op,
    input  logic [63:0]              a,
    input  logic [63:0]              b,
    output logic [63:0]              y
);

    import fltpm_pkg::*;

    always_comb begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

>>> src/four_level_page_table_mapper_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_core
// Walks four levels of 512-entry tables per map request, allocating missing
// tables from a bump allocator and writing the leaf entry.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Payload
//  s_       in   s_tvalid/s_tready    virt_addr, phys_addr, entry_flags
//  m_       out  m_tvalid/m_tready    tuser: status; tdata: new_tables, slot, entry
//  cfg_     in   cfg_wr_en            table_base
//
//  A mapped request passes through three levels of read, check, optional link
//  write and offset decode through the single table RAM port and the shared
//  adder, then the leaf write and the result load. A failing walk stops at the
//  failing level. After reset all NUM_TABLES*512 table RAM entries are swept
//  to zero with s_tready low; cfg writes are taken during the sweep.
//  A finished result waits in the output register; the next word is taken
//  meanwhile and its result holds until the output register is free.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper_core #(
    parameter int NUM_TABLES = fltpm_pkg::NUM_TABLES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fltpm_pkg::BASE_W-1:0]      cfg_wr_data,   // table_base
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [47:0] virt_addr, [99:48] phys_addr, [163:100] entry_flags, [167:164] zero
    input  logic [fltpm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] new_tables, [7:2] leaf_slot, [71:8] leaf_entry
    output logic [fltpm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tuser        // [0] status
);

    import fltpm_pkg::*;

    localparam int SLOT_W = $clog2(NUM_TABLES);
    localparam int NF_W   = $clog2(NUM_TABLES + 1);
    localparam int AW     = SLOT_W + IDX_W;
    localparam int DEPTH  = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int MEM_W  = ENTRY_W + 1;   // {written-after-alloc tag, entry}

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WLINK,
        ST_OFFS,
        ST_LEAF,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [PFN_W-1:0]    tbase_reg;
    logic [NF_W-1:0]     next_free_reg;
    logic [AW-1:0]       clr_addr_reg;

    logic [VIRT_W-1:0]   virt_reg;
    logic [PFN_W-1:0]    phys_pfn_reg;
    logic [ENTRY_W-1:0]  flags_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [1:0]          lvl_reg;
    logic [1:0]          made_reg;
    logic                fail_reg;
    logic [ENTRY_W-1:0]  entry_reg;

    logic                m_tvalid_reg;
    logic                m_status_reg;
    logic [1:0]          m_made_reg;
    logic [5:0]          m_slot_reg;
    logic [ENTRY_W-1:0]  m_entry_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [MEM_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [MEM_W-1:0]    ram_rdata;

    fltpm_alu_op_t       alu_op;
    logic [63:0]         alu_a;
    logic [63:0]         alu_b;
    logic [63:0]         alu_y;

    logic [ENTRY_W-1:0]  base_page;
    logic [ENTRY_W-1:0]  leaf_val;
    logic [ENTRY_W-1:0]  entry_eff;
    logic [AW-1:0]       walk_addr;
    logic                slot_alloc;
    logic                pool_empty;
    logic                off_bad;
    logic [SLOT_W+5:0]   slot_wide;

    assign base_page  = pfn_to_addr(tbase_reg);
    assign leaf_val   = pfn_to_addr(phys_pfn_reg) | flags_reg;
    assign walk_addr  = {slot_reg, page_index(virt_reg, lvl_reg)};
    // Slot was handed out (slot 0 always). Entries of such a slot written
    // before its allocation carry tag 0 and read as the cleared value.
    assign slot_alloc = NF_W'(slot_reg) < next_free_reg;
    assign entry_eff  = (slot_alloc && !ram_rdata[ENTRY_W]) ? '0 : ram_rdata[ENTRY_W-1:0];
    assign pool_empty = next_free_reg >= NF_W'(NUM_TABLES);
    assign off_bad    = alu_y[63:PAGE_SHIFT] >= (64 - PAGE_SHIFT)'(NUM_TABLES);
    assign slot_wide  = {6'b0, slot_reg};

    fltpm_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    fltpm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        ram_raddr = walk_addr;
        ram_waddr = walk_addr;
        ram_we    = 1'b0;
        ram_wdata = {slot_alloc, entry_reg};
        alu_op    = ALU_ADD;
        alu_a     = base_page;
        alu_b     = 64'(next_free_reg) << PAGE_SHIFT;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_WLINK: ram_we = 1'b1;
            ST_OFFS: begin
                alu_op = ALU_SUB;
                alu_a  = entry_reg & ~64'hFFF;
                alu_b  = base_page;
            end
            ST_LEAF: begin
                ram_we    = 1'b1;
                ram_wdata = {slot_alloc, leaf_val};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            tbase_reg     <= '0;
            next_free_reg <= NF_W'(1);
            clr_addr_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tbase_reg <= cfg_wr_data[BASE_W-1:PAGE_SHIFT];
            end
            // in ST_DONE the result load below decides the valid flag
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        virt_reg     <= s_tdata[VIRT_W-1:0];
                        phys_pfn_reg <= s_tdata[VIRT_W+PAGE_SHIFT +: PFN_W];
                        flags_reg    <= s_tdata[VIRT_W+PHYS_W +: ENTRY_W];
                        slot_reg     <= '0;
                        lvl_reg      <= 2'd0;
                        made_reg     <= 2'd0;
                        fail_reg     <= STATUS_OK;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_CHECK;
                ST_CHECK: begin
                    if (entry_eff[BIT_PRESENT]) begin
                        entry_reg <= entry_eff;
                        state_reg <= ST_OFFS;
                    end else if (pool_empty) begin
                        fail_reg  <= STATUS_NO_SLOT;
                        state_reg <= ST_DONE;
                    end else begin
                        // fresh table at base + slot * 4K
                        entry_reg     <= alu_y | LINK_FLAGS;
                        next_free_reg <= next_free_reg + NF_W'(1);
                        made_reg      <= made_reg + 2'd1;
                        state_reg     <= ST_WLINK;
                    end
                end
                ST_WLINK: state_reg <= ST_OFFS;
                ST_OFFS: begin
                    if (off_bad) begin
                        fail_reg  <= STATUS_NO_SLOT;
                        state_reg <= ST_DONE;
                    end else begin
                        slot_reg  <= alu_y[PAGE_SHIFT +: SLOT_W];
                        lvl_reg   <= lvl_reg + 2'd1;
                        state_reg <= (lvl_reg == 2'd2) ? ST_LEAF : ST_READ;
                    end
                end
                ST_LEAF: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= fail_reg;
                        m_made_reg   <= made_reg;
                        m_slot_reg   <= fail_reg ? 6'd0 : slot_wide[5:0];
                        m_entry_reg  <= fail_reg ? '0 : leaf_val;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_entry_reg, m_slot_reg, m_made_reg};

    // one word in flight: accept is followed by a busy cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a walk is in progress");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_free_reg <= NF_W'(NUM_TABLES)) && (next_free_reg != '0))
        else $error("allocator pointer out of range");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[M_TDATA_W-1:2] == '0))
        else $error("failed word carries a slot or entry");

    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_tready && ram_we))
        else $error("input taken during table sweep");

    a_alloc_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WLINK) |-> (next_free_reg == $past(next_free_reg) + NF_W'(1)))
        else $error("link written without an allocation");

endmodule

>>> tb/fltpm_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpm_map_checker
// Watches the request, result and config ports of the page table mapper.
// Replays every accepted map request on a private copy of the table store
// and allocator, and compares each result word field by field.
// ----------------------------------------------------------------------------
module fltpm_map_checker #(
    parameter int NUM_TABLES = fltpm_pkg::NUM_TABLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fltpm_pkg::BASE_W-1:0]    cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fltpm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fltpm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    output int                              mismatch_count,
    output int                              results_seen,
    output int                              no_slot_count
);
    import fltpm_pkg::*;

    typedef struct packed {
        logic               status;
        logic [1:0]         new_tables;
        logic [5:0]         leaf_slot;
        logic [ENTRY_W-1:0] leaf_entry;
    } map_result_t;

    localparam int STORE_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int MAX_SHOWN   = 40;

    logic [ENTRY_W-1:0] page_store [STORE_DEPTH];
    int                 next_slot;
    logic [BASE_W-1:0]  table_base;
    map_result_t        pending_maps[$];

    int fail_total    = 0;
    int result_total  = 0;
    int no_slot_total = 0;

    assign mismatch_count = fail_total;
    assign results_seen   = result_total;
    assign no_slot_count  = no_slot_total;

    task automatic report_mismatch(input string msg);
        if (fail_total < MAX_SHOWN)
            $display("[%0t] MISMATCH: %s", $time, msg);
        fail_total++;
    endtask

    // Walks the three upper levels, linking fresh tables where needed, then
    // writes the leaf. Any failure leaves earlier links in place.
    function automatic map_result_t map_page(input logic [VIRT_W-1:0]  va,
                                             input logic [PHYS_W-1:0]  pa,
                                             input logic [ENTRY_W-1:0] fl);
        map_result_t        res;
        int                 level_shift [3] = '{SHIFT_L4, SHIFT_L3, SHIFT_L2};
        logic [ENTRY_W-1:0] base_page;
        logic [ENTRY_W-1:0] entry;
        logic [ENTRY_W-1:0] offset;
        int                 slot;
        int                 made;
        int                 idx;
        int                 pos;
        bit                 failed;

        base_page = {12'b0, table_base[BASE_W-1:PAGE_SHIFT], 12'b0};
        slot      = 0;
        made      = 0;
        failed    = 1'b0;
        for (int lvl = 0; lvl < 3 && !failed; lvl++) begin
            idx   = int'((va >> level_shift[lvl]) & 48'h1FF);
            pos   = slot * ENTRIES_PER_TABLE + idx;
            entry = page_store[pos];
            if (!entry[BIT_PRESENT]) begin
                if (next_slot >= NUM_TABLES) begin
                    failed = 1'b1;
                end else begin
                    for (int i = 0; i < ENTRIES_PER_TABLE; i++)
                        page_store[next_slot * ENTRIES_PER_TABLE + i] = '0;
                    entry = (base_page + 64'(next_slot) * 64'd4096) | LINK_FLAGS;
                    page_store[pos] = entry;
                    next_slot++;
                    made++;
                end
            end
            if (!failed) begin
                // wraps mod 2^64; a stale base pushes the offset out of range
                offset = {entry[ENTRY_W-1:PAGE_SHIFT], 12'b0} - base_page;
                if (offset[ENTRY_W-1:PAGE_SHIFT] >= NUM_TABLES)
                    failed = 1'b1;
                else
                    slot = int'(offset[ENTRY_W-1:PAGE_SHIFT]);
            end
        end

        res.new_tables = made[1:0];
        if (failed) begin
            res.status     = STATUS_NO_SLOT;
            res.leaf_slot  = '0;
            res.leaf_entry = '0;
        end else begin
            res.status     = STATUS_OK;
            res.leaf_slot  = slot[5:0];
            res.leaf_entry = {12'b0, pa[PHYS_W-1:PAGE_SHIFT], 12'b0} | fl;
            page_store[slot * ENTRIES_PER_TABLE + int'(va[SHIFT_L1 +: IDX_W])] =
                res.leaf_entry;
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        map_result_t got;
        map_result_t want;

        if (!aresetn) begin
            foreach (page_store[i]) page_store[i] = '0;
            next_slot  = 1;
            table_base = '0;
            pending_maps.delete();
            result_total <= 0;
        end else begin
            if (cfg_wr_en)
                table_base = cfg_wr_data;

            // results first, so a word cannot match a request taken at this edge
            if (m_tvalid && m_tready) begin
                got.status     = m_tuser;
                got.new_tables = m_tdata[1:0];
                got.leaf_slot  = m_tdata[7:2];
                got.leaf_entry = m_tdata[71:8];
                result_total <= result_total + 1;
                if (pending_maps.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no request pending", got));
                end else begin
                    want = pending_maps.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.new_tables != want.new_tables)
                        report_mismatch($sformatf("new_tables %0d, expected %0d",
                                                  got.new_tables, want.new_tables));
                    if (got.leaf_slot != want.leaf_slot)
                        report_mismatch($sformatf("leaf_slot %0d, expected %0d",
                                                  got.leaf_slot, want.leaf_slot));
                    if (got.leaf_entry != want.leaf_entry)
                        report_mismatch($sformatf("leaf_entry %h, expected %h",
                                                  got.leaf_entry, want.leaf_entry));
                    if (want.status == STATUS_NO_SLOT)
                        no_slot_total++;
                end
            end

            if (s_tvalid && s_tready)
                pending_maps.push_back(map_page(s_tdata[VIRT_W-1:0],
                                                s_tdata[VIRT_W +: PHYS_W],
                                                s_tdata[VIRT_W+PHYS_W +: ENTRY_W]));
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Map request stimulus for the four-level page table mapper: directed walks
// over index extremes, then random requests that mostly reuse walked paths,
// under changing table bases and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import fltpm_pkg::*;

    localparam int ITEMS_PER_PHASE = 75;
    localparam int NUM_PHASES      = 8;
    localparam int WATCHDOG_LIMIT  = 200000;   // must outlast the reset clear sweep
    localparam int DRAIN_CYCLES    = 30;
    localparam int PAD_W           = S_TDATA_W - VIRT_W - PHYS_W - ENTRY_W;
    localparam logic [BASE_W-1:0] BASE_MAX = '1;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [BASE_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tready    = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int mismatch_count;
    int results_seen;
    int no_slot_count;

    int words_sent     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;

    logic [VIRT_W-1:0] walked_vas[$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    four_level_page_table_mapper_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    fltpm_map_checker u_map_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_seen   (results_seen),
        .no_slot_count  (no_slot_count)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [VIRT_W-1:0]  va,
                             input logic [PHYS_W-1:0]  pa,
                             input logic [ENTRY_W-1:0] fl);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, fl, pa, va};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        walked_vas.push_back(va);
    endtask

    // Most requests follow an already walked path so the leaf level is
    // exercised long after the allocator runs dry.
    task automatic send_random_word;
        logic [VIRT_W-1:0] va;
        logic [VIRT_W-1:0] prior;
        int                pick;

        va   = VIRT_W'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (walked_vas.size() != 0 && pick >= 4) begin
            prior = walked_vas[$urandom_range(walked_vas.size() - 1)];
            if (pick >= 16)
                va[47:21] = prior[47:21];
            else if (pick >= 10)
                va[47:30] = prior[47:30];
            else
                va[47:39] = prior[47:39];
        end
        send_word(va, PHYS_W'({$urandom, $urandom}), {$urandom, $urandom});
    endtask

    task automatic write_table_base(input logic [BASE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (results_seen < words_sent) @(posedge aclk);
    endtask

    initial begin
        int                mode;
        logic [BASE_W-1:0] next_base;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // only the ignored low bits are set: base stays at zero
        write_table_base(52'h0_0000_0000_0ABC);

        send_word(48'h0000_0000_0000, 52'h0_0000_0000_0000, 64'h0);
        send_word(48'h0000_0000_0000, 52'hF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 64'h0);
        send_word(48'h0000_0000_1000, 52'h0_0000_0000_1000, 64'h8000_0000_0000_0001);
        send_word(48'h0000_0020_0000, 52'h0_0000_1234_5000, 64'h7);
        send_word(48'h0000_4000_0000, 52'h8_0000_0000_0000, 64'h0);
        send_word(48'h0080_0000_0000, 52'h0_0000_0000_0FFF, 64'h2);
        send_word(48'hFF80_0000_0000, 52'h1_0000_0000_0000, 64'h0);
        send_word(48'h0000_3FE0_0000, 52'h0_ABCD_EF01_2000, 64'h0);
        send_word(48'h0000_001F_F000, 52'h0_0000_0000_3000, 64'h1);
        send_word(48'h0000_0000_0FFF, 52'h0_0000_0000_4000, 64'h0);
        send_word(48'h1234_5678_9ABC, 52'h1_2345_6789_AFFF, 64'h0);
        send_word(48'h1234_5678_9ABC, 52'h0_0000_0000_0000, 64'hFFF0_0000_0000_0FFF);
        send_word(48'h5555_5555_5000, 52'hA_AAAA_AAAA_A000, 64'h5555_5555_5555_5555);
        send_word(48'hAAAA_AAAA_A000, 52'h5_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(48'h7FFF_FFFF_F000, 52'h7_FFFF_FFFF_F000, 64'h0);
        send_word(48'h8000_0000_0000, 52'h8_0000_0000_0000, 64'h8000_0000_0000_0000);

        // base changes leave earlier links pointing outside the store
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                1, 6:    next_base = BASE_MAX;
                2, 5:    next_base = BASE_W'({$urandom, $urandom});
                4:       next_base = 52'h0_0000_0000_0FFF;
                default: next_base = '0;
            endcase
            write_table_base(next_base);
            mode = phase % 4;
            src_idle_pct   = (mode == 1) ? 64 : (mode == 3) ? 10 : 0;
            sink_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 10 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_word();
        end

        drain_results();
        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d map requests over %0d phases with idle/stall mixes and base swaps.",
                 words_sent, NUM_PHASES);
        $display("Checked %0d result words, %0d of them failed walks.",
                 results_seen, no_slot_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> four_level_page_table_mapper_core.f
src/fltpm_pkg.sv
src/fltpm_ram.sv
src/fltpm_alu.sv
src/four_level_page_table_mapper_core.sv
tb/fltpm_map_checker.sv
tb/testbench.sv
